/* rtl/srm_pkg.sv */
// shared types and constants for the sorted run merge block
`timescale 1ns / 1ps
`default_nettype none
package srm_pkg;

    localparam int OLDER_DEPTH = 32;
    localparam int KEY_BYTES   = 9;

    localparam int FILL_W = $clog2(OLDER_DEPTH + 1);
    localparam int ADDR_W = (OLDER_DEPTH > 1) ? $clog2(OLDER_DEPTH) : 1;

    // key bytes beyond the key length take no part in the key
    localparam logic [63:0] REST_MASK = {64{1'b1}} << (8 * (9 - KEY_BYTES));

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_MERGE = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  key_top;
        logic [63:0] key_rest;
        logic [31:0] value_loc;
        logic        live;
    } item_t;

    typedef struct packed {
        logic [7:0]  key_top;
        logic [63:0] key_rest;
        logic [31:0] value_loc;
        logic        live;
    } older_t;

    typedef struct packed {
        logic [7:0]  key_top;
        logic [63:0] key_rest;
        logic [31:0] value_loc;
    } rec_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

/* rtl/srm_front.sv */
// input side: decodes and masks requests into a two-entry queue
`timescale 1ns / 1ps
`default_nettype none
module srm_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire  [1:0]           s_opcode,
    input  wire  [7:0]           s_key_top_byte,
    input  wire  [63:0]          s_key_rest,
    input  wire  [31:0]          s_value_loc,
    input  wire                  s_live,
    output logic                 q_valid,
    output srm_pkg::item_t       q_item,
    input  wire                  q_pop
);
    import srm_pkg::*;

    item_t       q_mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        keep;
    item_t       in_item;

    always_comb begin
        in_item.key_top   = s_key_top_byte;
        in_item.key_rest  = s_key_rest & REST_MASK;
        in_item.value_loc = s_value_loc;
        in_item.live      = s_live;
        unique case (s_opcode)
            OP_LOAD: begin
                in_item.op = OP_LOAD;
                keep       = 1'b1;
            end
            OP_MERGE: begin
                in_item.op = OP_MERGE;
                keep       = 1'b1;
            end
            OP_FLUSH: begin
                in_item.op = OP_FLUSH;
                keep       = 1'b1;
            end
            // unused opcode is taken and dropped here
            default: begin
                in_item.op = OP_LOAD;
                keep       = 1'b0;
            end
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready && keep;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

/* rtl/srm_back.sv */
// merge engine: older record store, merge sequencer and result register
`timescale 1ns / 1ps
`default_nettype none
module srm_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  q_valid,
    input  srm_pkg::item_t       q_item,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire                  m_ready,
    output logic [7:0]           m_out_key_top_byte,
    output logic [63:0]          m_out_key_rest,
    output logic [31:0]          m_out_value_loc,
    output logic                 m_last
);
    import srm_pkg::*;

    older_t              mem [OLDER_DEPTH];
    older_t              rd_reg;
    logic                mem_we;

    state_t              state_reg, state_next;
    item_t               cur_reg, cur_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FILL_W-1:0]   rp_reg, rp_next;
    rec_t                pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    rec_t                out_reg, out_next;
    logic                out_last_reg, out_last_next;
    logic                m_valid_reg, m_valid_next;

    logic                out_free;
    logic                out_load;
    logic                have_old;
    logic                older_lt;
    logic                older_eq;
    logic                take_old;
    logic                slot_ok;
    rec_t                old_rec;
    rec_t                new_rec;

    assign out_free = !m_valid_reg || m_ready;
    assign have_old = rp_reg < fill_reg;
    assign older_lt = {rd_reg.key_top, rd_reg.key_rest} < {cur_reg.key_top, cur_reg.key_rest};
    assign older_eq = {rd_reg.key_top, rd_reg.key_rest} == {cur_reg.key_top, cur_reg.key_rest};
    assign take_old = have_old && ((cur_reg.op == OP_FLUSH) || older_lt);
    // the held result can make room for a new one
    assign slot_ok  = !pend_valid_reg || out_free;

    assign old_rec = '{key_top: rd_reg.key_top, key_rest: rd_reg.key_rest,
                       value_loc: rd_reg.value_loc};
    assign new_rec = '{key_top: cur_reg.key_top, key_rest: cur_reg.key_rest,
                       value_loc: cur_reg.value_loc};

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        fill_next       = fill_reg;
        rp_next         = rp_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_load        = 1'b0;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    if (q_item.op == OP_LOAD) begin
                        // loads past capacity are dropped
                        if (fill_reg < FILL_W'(OLDER_DEPTH)) begin
                            mem_we    = 1'b1;
                            fill_next = fill_reg + FILL_W'(1);
                        end
                    end else begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (take_old) begin
                    if (!rd_reg.live) begin
                        rp_next = rp_reg + FILL_W'(1);
                    end else if (slot_ok) begin
                        out_load        = pend_valid_reg;
                        out_last_next   = 1'b0;
                        pend_next       = old_rec;
                        pend_valid_next = 1'b1;
                        rp_next         = rp_reg + FILL_W'(1);
                    end
                end else if (cur_reg.op == OP_MERGE) begin
                    if (!cur_reg.live || slot_ok) begin
                        // an equal older key is consumed either way
                        if (have_old && older_eq) begin
                            rp_next = rp_reg + FILL_W'(1);
                        end
                        if (cur_reg.live) begin
                            out_load        = pend_valid_reg;
                            out_last_next   = 1'b0;
                            pend_next       = new_rec;
                            pend_valid_next = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                end else begin
                    fill_next  = '0;
                    rp_next    = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_load        = 1'b1;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        out_next     = out_load ? pend_reg : out_reg;
        m_valid_next = out_load || (m_valid_reg && !m_ready);
        if (!out_load) begin
            out_last_next = out_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            rp_reg         <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            rp_reg         <= rp_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // store: one write port at the fill point, registered read at the next read pointer
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[fill_reg[ADDR_W-1:0]] <= '{key_top: q_item.key_top, key_rest: q_item.key_rest,
                                           value_loc: q_item.value_loc, live: q_item.live};
        end
        rd_reg <= mem[rp_next[ADDR_W-1:0]];
    end

    assign m_valid            = m_valid_reg;
    assign m_out_key_top_byte = out_reg.key_top;
    assign m_out_key_rest     = out_reg.key_rest;
    assign m_out_value_loc    = out_reg.value_loc;
    assign m_last             = out_last_reg;

endmodule
`default_nettype wire

/* rtl/sorted_run_merge_with_tombstones.sv */
// Two-way compaction merge of an older sorted run (loaded with opcode 0 into a
// 32-entry store) against newer records (opcode 1), with tombstones dropped;
// opcode 2 flushes the remaining live older records and empties the store.
// A two-entry request queue decouples the input from the merge engine. A merge
// or flush steps through the stored older records it passes over (for a merge
// those with smaller keys, for a flush every remaining one) through the single
// registered read port of the store, and waits while the result side stalls.
// One result is held back inside the engine so that last can be marked on the
// final result of each request; results leave through an output register.
`timescale 1ns / 1ps
`default_nettype none
module sorted_run_merge_with_tombstones (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_valid,
    output logic         s_ready,
    input  wire  [1:0]   s_opcode,
    input  wire  [7:0]   s_key_top_byte,
    input  wire  [63:0]  s_key_rest,
    input  wire  [31:0]  s_value_loc,
    input  wire          s_live,
    output logic         m_valid,
    input  wire          m_ready,
    output logic [7:0]   m_out_key_top_byte,
    output logic [63:0]  m_out_key_rest,
    output logic [31:0]  m_out_value_loc,
    output logic         m_last
);
    import srm_pkg::*;

    logic   q_valid;
    item_t  q_item;
    logic   q_pop;

    srm_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_key_top_byte (s_key_top_byte),
        .s_key_rest     (s_key_rest),
        .s_value_loc    (s_value_loc),
        .s_live         (s_live),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    srm_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (q_valid),
        .q_item             (q_item),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_key_top_byte (m_out_key_top_byte),
        .m_out_key_rest     (m_out_key_rest),
        .m_out_value_loc    (m_out_value_loc),
        .m_last             (m_last)
    );

endmodule
`default_nettype wire

/* rtl/srm_checker.sv */
// port level checks for the sorted run merge block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module srm_checker (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_valid,
    input  wire          s_ready,
    input  wire  [1:0]   s_opcode,
    input  wire  [7:0]   s_key_top_byte,
    input  wire  [63:0]  s_key_rest,
    input  wire  [31:0]  s_value_loc,
    input  wire          s_live,
    input  wire          m_valid,
    input  wire          m_ready,
    input  wire  [7:0]   m_out_key_top_byte,
    input  wire  [63:0]  m_out_key_rest,
    input  wire  [31:0]  m_out_value_loc,
    input  wire          m_last
);

    // a waiting request holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_opcode) && $stable(s_key_top_byte)
            && $stable(s_key_rest) && $stable(s_value_loc) && $stable(s_live))
        else $error("waiting request changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_key_top_byte)
            && $stable(m_out_key_rest) && $stable(m_out_value_loc) && $stable(m_last))
        else $error("stalled result changed");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // queue is empty after reset, so a request is taken at once
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

endmodule

bind sorted_run_merge_with_tombstones srm_checker u_srm_checker (.*);
`default_nettype wire

/* test/sorted_run_merge_with_tombstones_tb.sv */
// self-checking testbench for the sorted run merge block with tombstones
`timescale 1ns / 1ps
module sorted_run_merge_with_tombstones_tb;
    import srm_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 200;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 200;

    typedef struct packed {
        rec_t rec;
        logic last;
    } emit_t;

    // merge predictor plus the queue of records it expects on the output
    class compaction_scoreboard;
        older_t      older_store [OLDER_DEPTH];
        int unsigned older_fill;
        int unsigned older_rd;
        emit_t       expected_records [$];
        int          errors;

        function new();
            older_fill = 0;
            older_rd   = 0;
            errors     = 0;
        endfunction

        function logic [71:0] key_of(int unsigned idx);
            return {older_store[idx].key_top, older_store[idx].key_rest};
        endfunction

        function int pending();
            return expected_records.size();
        endfunction

        function void note_request(logic [1:0] op, logic [7:0] top, logic [63:0] rest,
                                   logic [31:0] val, logic live);
            emit_t       batch [$];
            emit_t       tail;
            logic [63:0] mrest;
            mrest = rest & REST_MASK;
            if (op == OP_LOAD) begin
                // loads past capacity are dropped
                if (older_fill < OLDER_DEPTH) begin
                    older_store[older_fill] = {top, mrest, val, live};
                    older_fill++;
                end
            end else if (op == OP_MERGE) begin
                while (older_rd < older_fill && key_of(older_rd) < {top, mrest}) begin
                    if (older_store[older_rd].live)
                        batch.push_back({older_store[older_rd].key_top,
                                         older_store[older_rd].key_rest,
                                         older_store[older_rd].value_loc, 1'b0});
                    older_rd++;
                end
                // equal key: newer record wins, a newer tombstone drops both
                if (older_rd < older_fill && key_of(older_rd) == {top, mrest})
                    older_rd++;
                if (live)
                    batch.push_back({top, mrest, val, 1'b0});
            end else if (op == OP_FLUSH) begin
                while (older_rd < older_fill) begin
                    if (older_store[older_rd].live)
                        batch.push_back({older_store[older_rd].key_top,
                                         older_store[older_rd].key_rest,
                                         older_store[older_rd].value_loc, 1'b0});
                    older_rd++;
                end
                older_fill = 0;
                older_rd   = 0;
            end
            if (batch.size() > 0) begin
                tail = batch.pop_back();
                tail.last = 1'b1;
                batch.push_back(tail);
                foreach (batch[i])
                    expected_records.push_back(batch[i]);
            end
        endfunction

        function void check_record(logic [7:0] top, logic [63:0] rest,
                                   logic [31:0] val, logic last);
            emit_t want;
            if (expected_records.size() == 0) begin
                $display("%0t: unexpected result key %h_%h value %h last %b",
                         $time, top, rest, val, last);
                errors++;
                return;
            end
            want = expected_records.pop_front();
            if (want.rec.key_top !== top) begin
                $display("%0t: out_key_top_byte expected %h actual %h",
                         $time, want.rec.key_top, top);
                errors++;
            end
            if (want.rec.key_rest !== rest) begin
                $display("%0t: out_key_rest expected %h actual %h",
                         $time, want.rec.key_rest, rest);
                errors++;
            end
            if (want.rec.value_loc !== val) begin
                $display("%0t: out_value_loc expected %h actual %h",
                         $time, want.rec.value_loc, val);
                errors++;
            end
            if (want.last !== last) begin
                $display("%0t: last expected %b actual %b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [7:0]  s_key_top_byte;
    logic [63:0] s_key_rest;
    logic [31:0] s_value_loc;
    logic        s_live;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_key_top_byte;
    logic [63:0] m_out_key_rest;
    logic [31:0] m_out_value_loc;
    logic        m_last;

    compaction_scoreboard sb;
    int sent_count   = 0;
    bit steady       = 1'b0;
    bit hold_off_req = 1'b0;

    sorted_run_merge_with_tombstones dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_key_top_byte     (s_key_top_byte),
        .s_key_rest         (s_key_rest),
        .s_value_loc        (s_value_loc),
        .s_live             (s_live),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_key_top_byte (m_out_key_top_byte),
        .m_out_key_rest     (m_out_key_rest),
        .m_out_value_loc    (m_out_value_loc),
        .m_last             (m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_record(m_out_key_top_byte, m_out_key_rest, m_out_value_loc, m_last);
    end

    // receiver: random stalls, one long hold-off to back the block up
    initial begin
        bit held;
        held = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 35);
            end
        end
    end

    task automatic send_request(logic [1:0] op, logic [7:0] top, logic [63:0] rest,
                                logic [31:0] val, logic live);
        steady = (sent_count >= 110 && sent_count < 150);
        if (sent_count >= 60)
            hold_off_req = 1'b1;
        while (!steady && $urandom_range(99) < 35) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_key_top_byte <= top;
        s_key_rest     <= rest;
        s_value_loc    <= val;
        s_live         <= live;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_request(op, top, rest, val, live);
        if (op != OP_UNUSED)
            sent_count++;
    endtask

    task automatic maybe_noise();
        if ($urandom_range(9) == 0)
            send_request(2'($urandom_range(3)), 8'($urandom_range(255)),
                         {$urandom, $urandom}, $urandom, 1'($urandom_range(1)));
    endtask

    // one compaction round: sorted older run, sorted newer run, usually a flush
    task automatic run_sequence();
        int          n_older;
        int          n_newer;
        logic [71:0] base;
        logic [71:0] k;
        n_older = ($urandom_range(9) == 0) ? $urandom_range(34, 28) : $urandom_range(8);
        n_newer = $urandom_range(1, 8);
        base = {8'($urandom_range(255)), $urandom, $urandom};
        k = base;
        for (int i = 0; i < n_older; i++) begin
            k = k + 72'($urandom_range(3));
            send_request(OP_LOAD, k[71:64], k[63:0], $urandom, $urandom_range(3) != 0);
            maybe_noise();
        end
        k = base;
        for (int i = 0; i < n_newer; i++) begin
            k = k + 72'($urandom_range(4));
            // occasionally a top key that drains the whole store
            if (i == n_newer - 1 && $urandom_range(9) == 0)
                k = {72{1'b1}};
            send_request(OP_MERGE, k[71:64], k[63:0], $urandom, $urandom_range(3) != 0);
            maybe_noise();
        end
        if ($urandom_range(9) != 0)
            send_request(OP_FLUSH, 8'($urandom_range(255)), {$urandom, $urandom},
                         $urandom, 1'($urandom_range(1)));
    endtask

    initial begin
        sb = new();
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_opcode       <= OP_LOAD;
        s_key_top_byte <= '0;
        s_key_rest     <= '0;
        s_value_loc    <= '0;
        s_live         <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty store: live newer passes, tombstone vanishes, unused opcode ignored
        send_request(OP_MERGE, 8'h10, 64'h0123_4567_89ab_cdef, 32'h0000_0010, 1'b1);
        send_request(OP_MERGE, 8'h10, 64'h0123_4567_89ab_cdf0, 32'h0000_0011, 1'b0);
        send_request(OP_UNUSED, 8'hff, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 1'b1);
        send_request(OP_LOAD, 8'h00, 64'h0, 32'h0, 1'b1);
        send_request(OP_LOAD, 8'h40, 64'h1, 32'ha000_0001, 1'b1);
        send_request(OP_LOAD, 8'h40, 64'h2, 32'ha000_0002, 1'b0);
        send_request(OP_LOAD, 8'h40, 64'h3, 32'ha000_0003, 1'b1);
        send_request(OP_LOAD, 8'hff, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 1'b1);
        send_request(OP_MERGE, 8'h20, 64'h0, 32'hb000_0000, 1'b1);
        // equal key, live newer replaces older
        send_request(OP_MERGE, 8'h40, 64'h1, 32'hb000_0001, 1'b1);
        // equal key, newer tombstone drops both; older tombstone before it never shows
        send_request(OP_MERGE, 8'h40, 64'h3, 32'hb000_0003, 1'b0);
        send_request(OP_LOAD, 8'h01, 64'h0, 32'hc000_0000, 1'b1);
        // newer record below the read pointer
        send_request(OP_MERGE, 8'h00, 64'h5, 32'hb000_0005, 1'b1);
        send_request(OP_FLUSH, 8'h00, 64'h0, 32'h0, 1'b0);
        send_request(OP_MERGE, 8'hff, 64'hffff_ffff_ffff_ffff, 32'h1234_5678, 1'b0);
        send_request(OP_MERGE, 8'hff, 64'hffff_ffff_ffff_ffff, 32'h0, 1'b1);
        send_request(OP_FLUSH, 8'hff, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 1'b1);

        while (sent_count < 17 + RANDOM_ITEMS)
            run_sequence();
        s_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
